// ----- rtl/icwa_pkg.sv -----
// ----------------------------------------------------------------------------
// icwa_pkg
// Shared types and constants for the inertial counter window accumulator.
// ----------------------------------------------------------------------------
package icwa_pkg;

  localparam int SUM_WIDTH_DEF = 32;
  localparam int CNT_W         = 12;
  localparam int DELTA_W       = CNT_W + 1;
  localparam int NCHAN         = 7;
  localparam int TEMP_W        = 28;
  localparam int SPW_W         = 16;
  localparam int WPL_W         = 8;
  localparam int TIDX_W        = 3;
  localparam int CH_W          = 3;
  localparam int OUT_W         = 32;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 16;

  localparam logic [SPW_W-1:0]   SPW_RST   = 16'd128;
  localparam logic [WPL_W-1:0]   WPL_RST   = 8'd30;
  localparam logic [CNT_W-1:0]   LIMIT_RST = 12'd512;
  localparam logic [NCHAN-1:0]   MASK_RST  = 7'd116;
  localparam logic [DELTA_W-1:0] ACC_WRAP  = 13'd4096;
  localparam logic [TIDX_W-1:0]  TIDX_MAX  = 3'd5;
  localparam logic [CH_W-1:0]    CH_TEMP   = 3'd7;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPW   = 2'd0,
    CFG_WPL   = 2'd1,
    CFG_LIMIT = 2'd2,
    CFG_MASK  = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [SPW_W-1:0] spw;
    logic [WPL_W-1:0] wpl;
    logic [CNT_W-1:0] limit;
    logic [NCHAN-1:0] mask;
  } cfg_t;

  typedef struct packed {
    logic [CNT_W-1:0] accel_x;
    logic [CNT_W-1:0] accel_y;
    logic [CNT_W-1:0] accel_z;
    logic [CNT_W-1:0] gyro_x_up;
    logic [CNT_W-1:0] gyro_x_down;
    logic [CNT_W-1:0] gyro_y_up;
    logic [CNT_W-1:0] gyro_y_down;
    logic [CNT_W-1:0] gyro_z_up;
    logic [CNT_W-1:0] gyro_z_down;
    logic [CNT_W-1:0] gyro_xr_up;
    logic [CNT_W-1:0] gyro_xr_down;
    logic [CNT_W-1:0] temperature;
  } sample_t;

  typedef struct packed {
    logic [CH_W-1:0]         channel;
    logic signed [OUT_W-1:0] window_sum;
    logic signed [OUT_W-1:0] long_total;
    logic                    long_valid;
    logic [TIDX_W-1:0]       temp_sensor;
    logic                    last;
  } result_t;

  typedef struct packed {
    logic              valid;
    logic              long_end;
    logic [TEMP_W-1:0] temp_sum;
    logic [TIDX_W-1:0] temp_index;
  } dump_t;

endpackage

// ----- rtl/icwa_sample_if.sv -----
// ----------------------------------------------------------------------------
// icwa_sample_if
// Sample tick channel: valid/ready with one sample beat.
// ----------------------------------------------------------------------------
interface icwa_sample_if;
  logic                valid;
  logic                ready;
  icwa_pkg::sample_t   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/icwa_result_if.sv -----
// ----------------------------------------------------------------------------
// icwa_result_if
// Result channel: valid/ready with one dump result beat.
// ----------------------------------------------------------------------------
interface icwa_result_if;
  logic                valid;
  logic                ready;
  icwa_pkg::result_t   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/icwa_accum.sv -----
// ----------------------------------------------------------------------------
// icwa_accum
// Input register, channel deltas and window accumulation; snapshots the
// window sums into the dump stage at the end of each window.
// ----------------------------------------------------------------------------
module icwa_accum #(
  parameter int SUM_WIDTH = icwa_pkg::SUM_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  icwa_sample_if.sink             samples,
  input  icwa_pkg::cfg_t          cfg,
  input  logic                    dump_busy,
  output icwa_pkg::dump_t         dump,
  output logic [SUM_WIDTH-1:0]    win_snap [icwa_pkg::NCHAN]
);

  localparam int NCHAN = icwa_pkg::NCHAN;

  function automatic logic signed [icwa_pkg::DELTA_W-1:0] accel_delta(
    input logic [icwa_pkg::CNT_W-1:0] raw,
    input logic [icwa_pkg::CNT_W-1:0] limit
  );
    logic [icwa_pkg::DELTA_W-1:0] ext;
    ext = {1'b0, raw};
    if (raw > limit) begin
      ext = ext - icwa_pkg::ACC_WRAP;
    end
    return ext;
  endfunction

  function automatic logic signed [icwa_pkg::DELTA_W-1:0] gyro_delta(
    input logic [icwa_pkg::CNT_W-1:0] up,
    input logic [icwa_pkg::CNT_W-1:0] dn
  );
    return {1'b0, up} - {1'b0, dn};
  endfunction

  icwa_pkg::sample_t                    s1;
  logic                                 s1_valid;
  logic                                 s1_go;
  logic                                 dump_now;
  logic                                 long_end;
  logic signed [icwa_pkg::DELTA_W-1:0]  d [NCHAN];
  logic [SUM_WIDTH-1:0]                 window_sums [NCHAN];
  logic [SUM_WIDTH-1:0]                 win_next [NCHAN];
  logic [icwa_pkg::TEMP_W-1:0]          temp_sum;
  logic [icwa_pkg::TEMP_W-1:0]          temp_next;
  logic [icwa_pkg::SPW_W-1:0]           sample_counter;
  logic [icwa_pkg::WPL_W-1:0]           window_counter;
  logic [icwa_pkg::TIDX_W-1:0]          temp_index;
  logic [icwa_pkg::TIDX_W-1:0]          temp_index_next;

  assign dump_now      = sample_counter >= cfg.spw;
  assign long_end      = window_counter >= cfg.wpl;
  assign s1_go         = s1_valid && (!dump_now || (!dump_busy && !dump.valid));
  assign samples.ready = !s1_valid || s1_go;

  assign temp_index_next = (temp_index >= icwa_pkg::TIDX_MAX) ? '0
                                                               : temp_index + 1'b1;

  always_comb begin
    d[0] = accel_delta(s1.accel_x, cfg.limit);
    d[1] = accel_delta(s1.accel_y, cfg.limit);
    d[2] = accel_delta(s1.accel_z, cfg.limit);
    d[3] = gyro_delta(s1.gyro_x_up, s1.gyro_x_down);
    d[4] = gyro_delta(s1.gyro_y_up, s1.gyro_y_down);
    d[5] = gyro_delta(s1.gyro_z_up, s1.gyro_z_down);
    d[6] = gyro_delta(s1.gyro_xr_up, s1.gyro_xr_down);
    for (int c = 0; c < NCHAN; c++) begin
      if (cfg.mask[c]) begin
        win_next[c] = window_sums[c] - SUM_WIDTH'(d[c]);
      end else begin
        win_next[c] = window_sums[c] + SUM_WIDTH'(d[c]);
      end
    end
    temp_next = temp_sum + icwa_pkg::TEMP_W'(s1.temperature);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (samples.ready) begin
      s1_valid <= samples.valid;
    end
    if (samples.valid && samples.ready) begin
      s1 <= samples.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NCHAN; c++) begin
        window_sums[c] <= '0;
      end
      temp_sum       <= '0;
      sample_counter <= icwa_pkg::SPW_W'(1);
      window_counter <= icwa_pkg::WPL_W'(1);
      temp_index     <= '0;
      dump.valid     <= 1'b0;
    end else begin
      dump.valid <= s1_go && dump_now;
      if (s1_go) begin
        if (dump_now) begin
          for (int c = 0; c < NCHAN; c++) begin
            window_sums[c] <= '0;
            win_snap[c]    <= win_next[c];
          end
          temp_sum        <= '0;
          sample_counter  <= icwa_pkg::SPW_W'(1);
          window_counter  <= long_end ? icwa_pkg::WPL_W'(1) : window_counter + 1'b1;
          temp_index      <= temp_index_next;
          dump.long_end   <= long_end;
          dump.temp_sum   <= temp_next;
          dump.temp_index <= temp_index;
        end else begin
          for (int c = 0; c < NCHAN; c++) begin
            window_sums[c] <= win_next[c];
          end
          temp_sum       <= temp_next;
          sample_counter <= sample_counter + 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/icwa_dump.sv -----
// ----------------------------------------------------------------------------
// icwa_dump
// Holds one window snapshot, folds it into the long totals channel by
// channel and drains eight result beats through the output register.
// ----------------------------------------------------------------------------
module icwa_dump #(
  parameter int SUM_WIDTH = icwa_pkg::SUM_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  icwa_pkg::dump_t         dump,
  input  logic [SUM_WIDTH-1:0]    win_snap [icwa_pkg::NCHAN],
  output logic                    busy,
  icwa_result_if.source           results
);

  localparam int NCHAN = icwa_pkg::NCHAN;

  logic [SUM_WIDTH-1:0]          buf_win [NCHAN];
  logic [SUM_WIDTH-1:0]          long_totals [NCHAN];
  logic [icwa_pkg::TEMP_W-1:0]   buf_temp;
  logic [icwa_pkg::TIDX_W-1:0]   buf_tidx;
  logic                          buf_long;
  logic [icwa_pkg::CH_W-1:0]     k;
  logic [icwa_pkg::CH_W-1:0]     kc;
  logic                          drain;
  logic signed [SUM_WIDTH-1:0]   win_k;
  logic signed [SUM_WIDTH-1:0]   lt_sum;

  assign drain  = busy && (!results.valid || results.ready);
  assign kc     = (k == icwa_pkg::CH_TEMP) ? '0 : k;
  assign win_k  = buf_win[kc];
  assign lt_sum = long_totals[kc] + buf_win[kc];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      k             <= '0;
      results.valid <= 1'b0;
      for (int c = 0; c < NCHAN; c++) begin
        long_totals[c] <= '0;
      end
    end else begin
      if (drain) begin
        results.valid <= 1'b1;
      end else if (results.ready) begin
        results.valid <= 1'b0;
      end

      if (dump.valid) begin
        busy <= 1'b1;
        k    <= '0;
      end else if (drain) begin
        if (k == icwa_pkg::CH_TEMP) begin
          busy <= 1'b0;
          k    <= '0;
        end else begin
          long_totals[kc] <= buf_long ? '0 : lt_sum;
          k               <= k + 1'b1;
        end
      end
    end

    if (dump.valid) begin
      for (int c = 0; c < NCHAN; c++) begin
        buf_win[c] <= win_snap[c];
      end
      buf_temp <= dump.temp_sum;
      buf_tidx <= dump.temp_index;
      buf_long <= dump.long_end;
    end

    if (drain) begin
      results.data.channel    <= k;
      results.data.long_valid <= buf_long;
      if (k == icwa_pkg::CH_TEMP) begin
        results.data.window_sum  <= icwa_pkg::OUT_W'(buf_temp);
        results.data.long_total  <= '0;
        results.data.temp_sensor <= buf_tidx;
        results.data.last        <= 1'b1;
      end else begin
        results.data.window_sum  <= icwa_pkg::OUT_W'(win_k);
        results.data.long_total  <= buf_long ? icwa_pkg::OUT_W'(lt_sum) : '0;
        results.data.temp_sensor <= '0;
        results.data.last        <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/inertial_counter_window_accumulator.sv -----
// ----------------------------------------------------------------------------
// inertial_counter_window_accumulator
// Integrate-and-dump accumulator for accelerometer, gyro and temperature
// counts, with windowed sums and long-period totals.
// ----------------------------------------------------------------------------
// A sample beat is taken every cycle unless a closing window waits for the
// dump buffer; its seven channel deltas and the temperature are added from
// the input register into the window sums. At the end of a window the sums
// are copied into a dump buffer and eight result beats (channels 0..6, then
// temperature with last set) leave one per cycle while results are accepted,
// as new samples keep accumulating. The dump buffer holds one window, so a
// window that closes while the previous dump drains waits: sustained rate
// is one sample per cycle for windows of 10 or more samples; shorter
// windows hold off new samples. Configuration writes are meant for idle periods.
module inertial_counter_window_accumulator #(
  parameter int SUM_WIDTH = icwa_pkg::SUM_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [icwa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [icwa_pkg::CFG_DATA_W-1:0]     cfg_data,
  icwa_sample_if.sink                         samples,
  icwa_result_if.source                       results
);

  icwa_pkg::cfg_t           cfg;
  icwa_pkg::dump_t          dump;
  logic                     dump_busy;
  logic [SUM_WIDTH-1:0]     win_snap [icwa_pkg::NCHAN];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.spw   <= icwa_pkg::SPW_RST;
      cfg.wpl   <= icwa_pkg::WPL_RST;
      cfg.limit <= icwa_pkg::LIMIT_RST;
      cfg.mask  <= icwa_pkg::MASK_RST;
    end else if (cfg_we) begin
      unique case (icwa_pkg::cfg_idx_t'(cfg_index))
        icwa_pkg::CFG_SPW: begin
          cfg.spw <= cfg_data[icwa_pkg::SPW_W-1:0];
        end
        icwa_pkg::CFG_WPL: begin
          cfg.wpl <= cfg_data[icwa_pkg::WPL_W-1:0];
        end
        icwa_pkg::CFG_LIMIT: begin
          cfg.limit <= cfg_data[icwa_pkg::CNT_W-1:0];
        end
        icwa_pkg::CFG_MASK: begin
          cfg.mask <= cfg_data[icwa_pkg::NCHAN-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  icwa_accum #(
    .SUM_WIDTH (SUM_WIDTH)
  ) u_accum (
    .clk       (clk),
    .rst       (rst),
    .samples   (samples),
    .cfg       (cfg),
    .dump_busy (dump_busy),
    .dump      (dump),
    .win_snap  (win_snap)
  );

  icwa_dump #(
    .SUM_WIDTH (SUM_WIDTH)
  ) u_dump (
    .clk      (clk),
    .rst      (rst),
    .dump     (dump),
    .win_snap (win_snap),
    .busy     (dump_busy),
    .results  (results)
  );

`ifndef SYNTHESIS
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    dump.valid |-> !dump_busy)
    else $error("window snapshot while dump buffer busy");

  a_busy_after_snap: assert property (@(posedge clk) disable iff (rst)
    dump.valid |=> dump_busy)
    else $error("dump buffer not busy after snapshot");

  a_last_on_temp: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> (results.data.last == (results.data.channel == icwa_pkg::CH_TEMP)))
    else $error("last flag not on temperature beat");

  a_temp_zero_long: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.data.last) |-> (results.data.long_total == '0))
    else $error("temperature beat carries a long total");
`endif

endmodule

// ----- test/icwa_tb_pkg.sv -----
// ----------------------------------------------------------------------------
// icwa_tb_pkg
// Dump checker for the window accumulator: keeps its own window sums, long
// totals and counters, predicts eight dump beats when a sample ends a window
// and compares every result beat, field by field, with the oldest one due.
// ----------------------------------------------------------------------------
package icwa_tb_pkg;
  import icwa_pkg::*;

  localparam int SUM_W = SUM_WIDTH_DEF;

  class window_dump_checker;
    cfg_t              regs;
    logic [SUM_W-1:0]  win_sum [NCHAN];
    logic [SUM_W-1:0]  long_sum [NCHAN];
    logic [TEMP_W-1:0] temp_acc;
    logic [SPW_W-1:0]  sample_cnt;
    logic [WPL_W-1:0]  window_cnt;
    logic [TIDX_W-1:0] sensor_idx;
    result_t           due [$];
    int                failures;

    function new();
      regs = '{spw: SPW_RST, wpl: WPL_RST, limit: LIMIT_RST, mask: MASK_RST};
      foreach (win_sum[c]) begin
        win_sum[c]  = '0;
        long_sum[c] = '0;
      end
      temp_acc   = '0;
      sample_cnt = 1;
      window_cnt = 1;
      sensor_idx = '0;
      failures   = 0;
    endfunction

    function void set_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_SPW:   regs.spw   = val[SPW_W-1:0];
        CFG_WPL:   regs.wpl   = val[WPL_W-1:0];
        CFG_LIMIT: regs.limit = val[CNT_W-1:0];
        CFG_MASK:  regs.mask  = val[NCHAN-1:0];
        default: ;
      endcase
    endfunction

    function int accel_delta(input logic [CNT_W-1:0] raw);
      int v;
      v = raw;
      if (raw > regs.limit) v = v - int'(ACC_WRAP);
      return v;
    endfunction

    function int gyro_delta(input logic [CNT_W-1:0] up, input logic [CNT_W-1:0] dn);
      int u;
      int w;
      u = up;
      w = dn;
      return u - w;
    endfunction

    function logic signed [OUT_W-1:0] as_output(input logic [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] s;
      s = v;
      return s;
    endfunction

    function void take_sample(input sample_t s);
      int      d [NCHAN];
      logic    long_end;
      result_t r;
      d[0] = accel_delta(s.accel_x);
      d[1] = accel_delta(s.accel_y);
      d[2] = accel_delta(s.accel_z);
      d[3] = gyro_delta(s.gyro_x_up, s.gyro_x_down);
      d[4] = gyro_delta(s.gyro_y_up, s.gyro_y_down);
      d[5] = gyro_delta(s.gyro_z_up, s.gyro_z_down);
      d[6] = gyro_delta(s.gyro_xr_up, s.gyro_xr_down);
      for (int c = 0; c < NCHAN; c++) begin
        if (regs.mask[c]) begin
          win_sum[c] = win_sum[c] - SUM_W'(d[c]);
        end else begin
          win_sum[c] = win_sum[c] + SUM_W'(d[c]);
        end
      end
      temp_acc = temp_acc + s.temperature;

      // register at zero or below the counter: dump now
      if (sample_cnt < regs.spw) begin
        sample_cnt = sample_cnt + 1'b1;
        return;
      end
      sample_cnt = 1;
      long_end = (window_cnt >= regs.wpl);

      for (int c = 0; c < NCHAN; c++) begin
        long_sum[c]   = long_sum[c] + win_sum[c];
        r.channel     = CH_W'(c);
        r.window_sum  = as_output(win_sum[c]);
        r.long_total  = long_end ? as_output(long_sum[c]) : '0;
        r.long_valid  = long_end;
        r.temp_sensor = '0;
        r.last        = 1'b0;
        due.push_back(r);
        win_sum[c] = '0;
        if (long_end) long_sum[c] = '0;
      end
      r.channel     = CH_TEMP;
      r.window_sum  = {{(OUT_W-TEMP_W){1'b0}}, temp_acc};
      r.long_total  = '0;
      r.long_valid  = long_end;
      r.temp_sensor = sensor_idx;
      r.last        = 1'b1;
      due.push_back(r);

      temp_acc   = '0;
      sensor_idx = (sensor_idx >= TIDX_MAX) ? '0 : sensor_idx + 1'b1;
      window_cnt = long_end ? WPL_W'(1) : window_cnt + 1'b1;
    endfunction

    function void check_beat(input result_t got);
      result_t want;
      if (due.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("%0t: result beat with none due: ch=%0d win=%0d long=%0d",
                   $time, got.channel, got.window_sum, got.long_total);
        return;
      end
      want = due.pop_front();
      if (got.channel !== want.channel || got.window_sum !== want.window_sum ||
          got.long_total !== want.long_total || got.long_valid !== want.long_valid ||
          got.temp_sensor !== want.temp_sensor || got.last !== want.last) begin
        failures++;
        if (failures <= 10) begin
          $display("%0t: mismatch, expected ch=%0d win=%0d long=%0d lv=%0b ts=%0d last=%0b",
                   $time, want.channel, want.window_sum, want.long_total,
                   want.long_valid, want.temp_sensor, want.last);
          $display("%0t:           actual   ch=%0d win=%0d long=%0d lv=%0b ts=%0d last=%0b",
                   $time, got.channel, got.window_sum, got.long_total,
                   got.long_valid, got.temp_sensor, got.last);
        end
      end
    endfunction
  endclass

endpackage

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Testbench for the inertial counter window accumulator: directed extremes,
// then random samples over several register settings, with random stalls on
// both channels and a final quiet stretch. Results are checked beat by beat.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import icwa_pkg::*;
  import icwa_tb_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE      = 20;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  idle_on   = 1'b0;
  int                    rx_hold   = 0;
  int                    quiet_cycles = 0;
  window_dump_checker    chk;

  icwa_sample_if smp ();
  icwa_result_if res ();

  inertial_counter_window_accumulator uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .samples   (smp),
    .results   (res)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    if (rx_hold > 0) begin
      rx_hold = rx_hold - 1;
      res.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 6) == 0) begin
      rx_hold = $urandom_range(0, 17);
      res.ready <= 1'b0;
    end else begin
      res.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && res.valid && res.ready) chk.check_beat(res.data);
    if (rst || (res.valid && res.ready) || (smp.valid && smp.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [CNT_W-1:0] rand_count(input logic [CNT_W-1:0] near);
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return near + CNT_W'($urandom_range(0, 1));
      3: return near;
      default: return CNT_W'($urandom);
    endcase
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    s.accel_x      = rand_count(chk.regs.limit);
    s.accel_y      = rand_count(chk.regs.limit);
    s.accel_z      = rand_count(chk.regs.limit);
    s.gyro_x_up    = rand_count(chk.regs.limit);
    s.gyro_x_down  = rand_count(chk.regs.limit);
    s.gyro_y_up    = rand_count(chk.regs.limit);
    s.gyro_y_down  = rand_count(chk.regs.limit);
    s.gyro_z_up    = rand_count(chk.regs.limit);
    s.gyro_z_down  = rand_count(chk.regs.limit);
    s.gyro_xr_up   = rand_count(chk.regs.limit);
    s.gyro_xr_down = rand_count(chk.regs.limit);
    s.temperature  = rand_count(chk.regs.limit);
    return s;
  endfunction

  function automatic sample_t flat(input logic [CNT_W-1:0] a, input logic [CNT_W-1:0] up,
                                   input logic [CNT_W-1:0] dn, input logic [CNT_W-1:0] t);
    sample_t s;
    s.accel_x      = a;
    s.accel_y      = a;
    s.accel_z      = a;
    s.gyro_x_up    = up;
    s.gyro_x_down  = dn;
    s.gyro_y_up    = up;
    s.gyro_y_down  = dn;
    s.gyro_z_up    = up;
    s.gyro_z_down  = dn;
    s.gyro_xr_up   = up;
    s.gyro_xr_down = dn;
    s.temperature  = t;
    return s;
  endfunction

  // called at a falling edge, returns at the falling edge after the beat
  task automatic send_sample(input sample_t s);
    smp.valid <= 1'b1;
    smp.data  <= s;
    @(posedge clk);
    while (!smp.ready) @(posedge clk);
    chk.take_sample(s);
    @(negedge clk);
  endtask

  task automatic hold_off(input int n);
    smp.valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic drain();
    smp.valid <= 1'b0;
    while (chk.due.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    chk.set_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic reconfigure(input logic [SPW_W-1:0] spw, input logic [WPL_W-1:0] wpl,
                             input logic [CNT_W-1:0] limit, input logic [NCHAN-1:0] mask);
    drain();
    repeat (SETTLE) @(negedge clk);
    write_reg(CFG_SPW, spw);
    write_reg(CFG_WPL, wpl);
    write_reg(CFG_LIMIT, limit);
    write_reg(CFG_MASK, mask);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(input int n);
    for (int k = 0; k < n; k++) begin
      if (idle_on && $urandom_range(0, 4) == 0) hold_off($urandom_range(1, 18));
      send_sample(random_sample());
    end
  endtask

  initial begin
    chk       = new();
    smp.valid = 1'b0;
    smp.data  = '0;
    res.ready = 1'b0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    idle_on = 1'b1;
    reconfigure(1, 3, 12'd0, 7'h7f);
    send_sample(flat(12'd0, 12'd0, 12'd0, 12'd0));
    send_sample(flat(12'hfff, 12'hfff, 12'hfff, 12'hfff));
    send_sample(flat(12'd1, 12'hfff, 12'd0, 12'hfff));
    send_sample(flat(12'd0, 12'd0, 12'hfff, 12'd1));
    send_sample(random_sample());
    send_sample(random_sample());

    reconfigure(2, 1, 12'hfff, 7'h00);
    send_sample(flat(12'hfff, 12'hfff, 12'd0, 12'hfff));
    send_sample(flat(12'hfff, 12'hfff, 12'd0, 12'hfff));
    send_sample(flat(12'h800, 12'd0, 12'hfff, 12'd0));
    send_sample(flat(12'h800, 12'd0, 12'hfff, 12'd0));
    send_sample(flat(12'd0, 12'h800, 12'h800, 12'h800));
    send_sample(flat(12'd0, 12'h800, 12'h800, 12'h800));

    // zero window length acts as one
    reconfigure(0, 2, 12'h7ff, 7'h55);
    send_sample(flat(12'h7ff, 12'hfff, 12'd0, 12'd7));
    send_sample(flat(12'h800, 12'd0, 12'hfff, 12'hfff));
    send_sample(flat(12'hfff, 12'd5, 12'd9, 12'd3));
    send_sample(flat(12'd0, 12'd9, 12'd5, 12'hfff));
    send_sample(random_sample());
    send_sample(random_sample());

    reconfigure(3, 4, CNT_W'($urandom), NCHAN'($urandom));
    run_random(20);
    drain();
    run_random(20);

    reconfigure(16'hffff, 8'hff, LIMIT_RST, MASK_RST);
    run_random(20);
    // window length lowered below the running count
    reconfigure(5, 8'hff, CNT_W'($urandom), NCHAN'($urandom));
    run_random(40);

    reconfigure(1, 8'hff, CNT_W'($urandom), NCHAN'($urandom));
    run_random(212);

    idle_on = 1'b0;
    reconfigure(7, 1, 12'hfff, 7'h00);
    run_random(30);

    drain();
    repeat (SETTLE) @(posedge clk);
    if (chk.failures == 0 && chk.due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
